@@ hdl/rtt_pkg.sv @@
package rtt_pkg;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SCAN,
		ST_SCAN_WAIT,
		ST_EVICT,
		ST_CLAIM,
		ST_RD_ENTRY,
		ST_RD_WAIT,
		ST_SAMP_RD,
		ST_SAMP_WAIT,
		ST_SORT,
		ST_FILTER,
		ST_WRITE,
		ST_OUT
	} rtt_state_t;

	localparam logic [47:0] ADDR_ALL_ONES = 48'hFFFF_FFFF_FFFF;

	// q8 filter step: f + (m - f)/4, division truncating toward zero
	function automatic logic signed [15:0] filt_step(input logic signed [15:0] f,
			input logic signed [15:0] m);
		logic signed [17:0] d;
		logic signed [17:0] q;
		logic signed [17:0] s;
		begin
			d = 18'(m) - 18'(f);
			q = (d < 0) ? -((-d) >>> 2) : (d >>> 2);
			s = 18'(f) + q;
			filt_step = s[15:0];
		end
	endfunction

endpackage

@@ hdl/rssi_tracking_table_core.sv @@
// flow: a new entry takes a serial table scan, then a serial eviction scan when the table is
// full; a known entry takes a scan up to the hit, a read-back of each old sample, a serial
// insertion sort and the sample write-back; rejected addresses go straight to the result
// transaction, and an output stall holds the result until it is taken.
// throughput: one sighting at a time; in_stall is high until the result is taken, and the
// next input transaction is taken only in the idle state.
// reset: asynchronous active low; clears entry valid bits, sets next id to 1.
module rssi_tracking_table_core #(
	parameter int TABLE_ENTRIES  = 32,
	parameter int WINDOW_SAMPLES = 5
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [47:0] address,
	input  logic        is_ap,
	input  logic signed [7:0] rssi,
	input  logic [3:0]  channel,
	input  logic [31:0] now_ms,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        accepted,
	output logic [4:0]  slot,
	output logic [31:0] target_id,
	output logic        is_new,
	output logic        evicted,
	output logic signed [7:0] median_rssi,
	output logic signed [7:0] smooth_rssi,
	output logic [15:0] sighting_count,
	output logic [15:0] sequence_res,
	output logic        entry_is_ap
);
	import rtt_pkg::*;

	localparam int EW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CW = $clog2(TABLE_ENTRIES + 1);
	localparam int WW = $clog2(WINDOW_SAMPLES + 1);
	localparam int WX = WW + 1;
	localparam int SW = (WINDOW_SAMPLES > 1) ? $clog2(WINDOW_SAMPLES) : 1;
	localparam int SD = TABLE_ENTRIES * WINDOW_SAMPLES;
	localparam int SAW = (SD > 1) ? $clog2(SD) : 1;
	// entry record: addr, id, last_seen, count(WW), filt, cnt, seq, ap, chan
	localparam int RW = 48 + 32 + 32 + WW + 16 + 16 + 16 + 1 + 4;

	typedef struct packed {
		logic [47:0] addr;
		logic [31:0] id;
		logic [31:0] last;
		logic [WW-1:0] nsamp;
		logic [15:0] filt;
		logic [15:0] cnt;
		logic [15:0] seq;
		logic ap;
		logic [3:0] chan;
	} rec_t;

	rtt_state_t state_q, state_d;

	logic [TABLE_ENTRIES-1:0] valid_q;
	logic [31:0] next_id_q;
	logic [47:0] addr_q;
	logic ap_q;
	logic signed [7:0] rssi_q;
	logic [3:0] chan_q;
	logic [31:0] now_q;

	logic [CW-1:0] idx_q;      // scan address counter
	logic [EW-1:0] ent_q;      // chosen entry
	logic [EW-1:0] pick_q;     // eviction pick
	logic [31:0] pick_last_q;
	logic fresh_q, evict_q;
	rec_t rec_q;

	logic signed [7:0] win_q [WINDOW_SAMPLES];  // new window, oldest first
	logic signed [7:0] srt_q [WINDOW_SAMPLES];  // sorted prefix
	logic [WW-1:0] n_q;
	logic [WW-1:0] k_q;
	logic signed [7:0] med_q;
	logic signed [15:0] filt_q;

	// record ram
	logic rec_we;
	logic [EW-1:0] rec_waddr, rec_raddr;
	rec_t rec_wdata, rec_rdata;
	logic [RW-1:0] rec_rbits;

	rtt_ram #(.WIDTH(RW), .DEPTH(TABLE_ENTRIES)) u_rec (
		.clk(clk), .we(rec_we), .waddr(rec_waddr), .wdata(rec_wdata),
		.raddr(rec_raddr), .rdata(rec_rbits)
	);
	assign rec_rdata = rec_t'(rec_rbits);

	// sample ram
	logic smp_we;
	logic [SAW-1:0] smp_waddr, smp_raddr;
	logic [7:0] smp_wdata, smp_rdata;

	rtt_ram #(.WIDTH(8), .DEPTH(SD)) u_smp (
		.clk(clk), .we(smp_we), .waddr(smp_waddr), .wdata(smp_wdata),
		.raddr(smp_raddr), .rdata(smp_rdata)
	);

	logic [EW-1:0] idx_e;
	assign idx_e = idx_q[EW-1:0];
	logic [WW-1:0] nold;
	assign nold = fresh_q ? WW'(0) : rec_q.nsamp;
	logic full;
	assign full = (nold >= WW'(WINDOW_SAMPLES));
	logic [SW-1:0] k_s;
	assign k_s = k_q[SW-1:0];

	// old window slot read by the current pass
	logic [WX-1:0] rd_pos;
	assign rd_pos = WX'(k_q) + WX'(full);

	// scan match: rdata holds entry idx-1
	logic hit;
	assign hit = valid_q[EW'(idx_q - CW'(1))] && (rec_rdata.addr == addr_q);

	// lowest free entry
	logic [EW-1:0] free_e;
	always_comb begin
		free_e = '0;
		for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
			if (!valid_q[i]) free_e = EW'(i);
		end
	end

	// sample read address: entry*W + source index
	logic [SAW-1:0] smp_base;
	assign smp_base = SAW'(ent_q) * SAW'(WINDOW_SAMPLES);

	always_comb begin
		rec_raddr = idx_e;
		if (state_q == ST_RD_ENTRY || state_q == ST_RD_WAIT) begin
			rec_raddr = ent_q;
		end
		smp_raddr = smp_base + SAW'(full ? k_q + WW'(1) : k_q);
	end

	assign in_stall = (state_q != ST_IDLE);
	assign out_valid = (state_q == ST_OUT);

	// sequencer next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (in_valid) begin
				state_d = (address == 48'd0 || address == ADDR_ALL_ONES) ? ST_OUT : ST_SCAN;
			end
			ST_SCAN: state_d = ST_SCAN_WAIT;
			ST_SCAN_WAIT: begin
				if (hit) state_d = ST_RD_ENTRY;
				else if (idx_q == CW'(TABLE_ENTRIES)) begin
					state_d = (&valid_q) ? ST_EVICT : ST_CLAIM;
				end
			end
			ST_EVICT: if (idx_q == CW'(TABLE_ENTRIES)) state_d = ST_CLAIM;
			ST_CLAIM: state_d = (WINDOW_SAMPLES > 1) ? ST_SAMP_RD : ST_SORT;
			ST_RD_ENTRY: state_d = ST_RD_WAIT;
			ST_RD_WAIT: state_d = ST_SAMP_RD;
			ST_SAMP_RD: state_d = ST_SAMP_WAIT;
			ST_SAMP_WAIT: begin
				// another pass while old samples remain
				state_d = ST_SORT;
				if (rd_pos < WX'(nold) && rd_pos + WX'(1) < WX'(nold)) state_d = ST_SAMP_RD;
			end
			ST_SORT: if (k_q == n_q) state_d = ST_FILTER;
			ST_FILTER: state_d = ST_WRITE;
			ST_WRITE: if (k_q == n_q) state_d = ST_OUT;
			ST_OUT: if (!out_stall) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	// sort insertion of one value into sorted prefix of length k
	logic signed [7:0] ins_v;
	logic signed [7:0] srt_d [WINDOW_SAMPLES];
	always_comb begin
		ins_v = win_q[k_s];
		for (int i = 0; i < WINDOW_SAMPLES; i++) begin
			srt_d[i] = srt_q[i];
			if (WW'(i) <= k_q) begin
				if (WW'(i) == k_q) begin
					srt_d[i] = (i > 0 && srt_q[(i > 0) ? i - 1 : 0] > ins_v) ?
						srt_q[(i > 0) ? i - 1 : 0] : ins_v;
				end else if (srt_q[i] > ins_v) begin
					srt_d[i] = (i > 0 && srt_q[(i > 0) ? i - 1 : 0] > ins_v) ?
						srt_q[(i > 0) ? i - 1 : 0] : ins_v;
				end
			end
		end
	end

	// ram writes
	always_comb begin
		rec_we = (state_q == ST_FILTER);
		rec_waddr = ent_q;
		rec_wdata = rec_q;
		rec_wdata.addr = addr_q;
		rec_wdata.last = now_q;
		rec_wdata.nsamp = n_q;
		rec_wdata.filt = filt_step(filt_q, 16'(med_q) <<< 8);
		if (rec_q.cnt == 16'd0 || fresh_q) rec_wdata.filt = {med_q, 8'd0};
		rec_wdata.cnt = (fresh_q ? 16'd0 : rec_q.cnt);
		rec_wdata.cnt = (&rec_wdata.cnt) ? rec_wdata.cnt : rec_wdata.cnt + 16'd1;
		rec_wdata.seq = (fresh_q ? 16'd0 : rec_q.seq) + 16'd1;
		if (rec_wdata.seq == 16'd0) rec_wdata.seq = 16'd1;
		rec_wdata.ap = (fresh_q ? 1'b0 : rec_q.ap) | ap_q;
		rec_wdata.chan = chan_q;
		if (fresh_q) rec_wdata.id = next_id_q;
		smp_we = (state_q == ST_WRITE) && (k_q != n_q);
		smp_waddr = smp_base + SAW'(k_q);
		smp_wdata = win_q[k_s];
	end

	logic [31:0] dlt;
	assign dlt = rec_rdata.last - pick_last_q;

	// datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			next_id_q <= 32'd1;
		end else if (state_q == ST_CLAIM) begin
			valid_q[ent_q] <= 1'b1;
		end else if (state_q == ST_FILTER && fresh_q) begin
			next_id_q <= (next_id_q == 32'hFFFF_FFFF) ? 32'd1 : next_id_q + 32'd1;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				addr_q <= address; ap_q <= is_ap; rssi_q <= rssi;
				chan_q <= channel; now_q <= now_ms;
				idx_q <= '0; fresh_q <= 1'b0; evict_q <= 1'b0;
				accepted <= !(address == 48'd0 || address == ADDR_ALL_ONES);
			end
			ST_SCAN: idx_q <= idx_q + CW'(1);
			ST_SCAN_WAIT: begin
				// rdata is entry idx-1; advance the read address each cycle
				if (hit) begin
					ent_q <= EW'(idx_q - CW'(1));
				end else if (idx_q == CW'(TABLE_ENTRIES)) begin
					idx_q <= CW'(1);
					pick_q <= '0;
					pick_last_q <= 32'd0;
					ent_q <= free_e;
				end else begin
					idx_q <= idx_q + CW'(1);
				end
			end
			ST_EVICT: begin
				// rdata is entry idx-1; first cycle reads entry 0 as the initial pick
				if (idx_q == CW'(1)) pick_last_q <= rec_rdata.last;
				else if (dlt[31]) begin
					pick_q <= EW'(idx_q - CW'(1));
					pick_last_q <= rec_rdata.last;
				end
				if (idx_q != CW'(TABLE_ENTRIES)) idx_q <= idx_q + CW'(1);
				else begin
					ent_q <= dlt[31] ? EW'(idx_q - CW'(1)) : pick_q;
					evict_q <= 1'b1;
				end
			end
			ST_CLAIM: begin
				fresh_q <= 1'b1;
				rec_q.cnt <= '0; rec_q.seq <= '0; rec_q.nsamp <= '0; rec_q.ap <= 1'b0;
				rec_q.id <= next_id_q;
				k_q <= '0;
				n_q <= WW'(1);
				win_q[0] <= rssi_q;
			end
			ST_RD_WAIT: begin
				rec_q <= rec_rdata;
				k_q <= '0;
			end
			ST_SAMP_RD: begin
				// set window length and put new sample at the end
				n_q <= full ? WW'(WINDOW_SAMPLES) : nold + WW'(1);
				win_q[SW'(full ? WW'(WINDOW_SAMPLES - 1) : nold)] <= rssi_q;
				if (k_q + (full ? WW'(1) : WW'(0)) >= nold) begin
					k_q <= '0;
				end
			end
			ST_SAMP_WAIT: begin
				// one old sample a pass, read back and stored
				if (rd_pos < WX'(nold)) begin
					win_q[k_s] <= smp_rdata;
					k_q <= (rd_pos + WX'(1) < WX'(nold)) ? k_q + WW'(1) : '0;
				end else begin
					k_q <= '0;
				end
			end
			ST_SORT: begin
				if (k_q != n_q) begin
					srt_q <= srt_d;
					k_q <= k_q + WW'(1);
				end else begin
					med_q <= srt_q[SW'(n_q >> 1)];
					filt_q <= rec_q.filt;
				end
			end
			ST_FILTER: begin
				rec_q <= rec_wdata;
				k_q <= '0;
			end
			ST_WRITE: if (k_q != n_q) k_q <= k_q + WW'(1);
			default: ;
		endcase
	end

	// result fields
	assign slot = accepted ? 5'(ent_q) : 5'd0;
	assign target_id = accepted ? rec_q.id : 32'd0;
	assign is_new = accepted & fresh_q;
	assign evicted = accepted & evict_q;
	assign median_rssi = accepted ? med_q : 8'sd0;
	assign smooth_rssi = accepted ? 8'(($signed(rec_q.filt) < 0) ?
		-((-$signed(rec_q.filt)) >>> 8) : ($signed(rec_q.filt) >>> 8)) : 8'sd0;
	assign sighting_count = accepted ? rec_q.cnt : 16'd0;
	assign sequence_res = accepted ? rec_q.seq : 16'd0;
	assign entry_is_ap = accepted & rec_q.ap;
endmodule

@@ hdl/rtt_ram.sv @@
module rtt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// single write port, registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

@@ hdl/rtt_checker.sv @@
module rtt_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall,
	input logic accepted,
	input logic is_new,
	input logic evicted,
	input logic [31:0] target_id
);
	a_no_in_while_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall) else $error("input taken while result pending");
	a_id_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && accepted) |-> target_id != 32'd0) else $error("zero id");
	a_evict_new: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && evicted) |-> is_new) else $error("eviction without allocation");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> out_valid) else $error("result dropped");
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_stall) |=> in_valid) else $error("input withdrawn while stalled");
endmodule

bind rssi_tracking_table_core rtt_checker u_rtt_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .accepted(accepted),
	.is_new(is_new), .evicted(evicted), .target_id(target_id)
);

@@ dv/tb.sv @@
`timescale 1ns / 1ps

module tb;

	localparam int ENTRIES   = 32;
	localparam int WINDOW    = 5;
	localparam int STALL_MAX = 15;
	localparam int IDLE_LIMIT = 3000;
	localparam logic [47:0] BCAST = 48'hFFFF_FFFF_FFFF;

	typedef struct {
		logic        accepted;
		logic [4:0]  slot;
		logic [31:0] target_id;
		logic        is_new;
		logic        evicted;
		logic [7:0]  median_rssi;
		logic [7:0]  smooth_rssi;
		logic [15:0] sighting_count;
		logic [15:0] sequence_res;
		logic        entry_is_ap;
	} sighting_res_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [47:0] address = '0;
	logic is_ap = 1'b0;
	logic signed [7:0] rssi = '0;
	logic [3:0] channel = '0;
	logic [31:0] now_ms = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic accepted;
	logic [4:0] slot;
	logic [31:0] target_id;
	logic is_new;
	logic evicted;
	logic signed [7:0] median_rssi;
	logic signed [7:0] smooth_rssi;
	logic [15:0] sighting_count;
	logic [15:0] sequence_res;
	logic entry_is_ap;

	rssi_tracking_table_core #(
		.TABLE_ENTRIES(ENTRIES),
		.WINDOW_SAMPLES(WINDOW)
	) dut (.*);

	always #2 clk = ~clk;

	// shadow copy of the tracking table
	logic              tbl_valid [ENTRIES];
	logic [47:0]       tbl_addr  [ENTRIES];
	logic [31:0]       tbl_id    [ENTRIES];
	logic [31:0]       tbl_last  [ENTRIES];
	logic signed [7:0] tbl_samp  [ENTRIES][WINDOW];
	int                tbl_nsamp [ENTRIES];
	int                tbl_filt  [ENTRIES];
	logic [15:0]       tbl_count [ENTRIES];
	logic [15:0]       tbl_seq   [ENTRIES];
	logic              tbl_ap    [ENTRIES];
	logic [31:0]       id_next;

	sighting_res_t pending_results[$];
	int errors = 0;
	bit quiet = 1'b0;
	logic [31:0] clock_ms = 32'd100;
	logic [47:0] addr_pool[$];

	// table lookup, allocation, window and filter update for one sighting
	function automatic sighting_res_t track_sighting(logic [47:0] a, logic ap,
			logic signed [7:0] r, logic [31:0] t);
		sighting_res_t res;
		int e;
		int n;
		int j;
		int med;
		int f;
		logic signed [7:0] srt[WINDOW];
		logic signed [7:0] v;
		res = '{default: '0};
		if (a == '0 || a == BCAST)
			return res;
		e = -1;
		for (int i = 0; i < ENTRIES && e < 0; i++)
			if (tbl_valid[i] && tbl_addr[i] == a) e = i;
		if (e < 0) begin
			for (int i = 0; i < ENTRIES && e < 0; i++)
				if (!tbl_valid[i]) e = i;
			if (e < 0) begin
				e = 0;
				for (int i = 1; i < ENTRIES; i++)
					if ($signed(tbl_last[i] - tbl_last[e]) < 0) e = i;
				res.evicted = 1'b1;
			end
			res.is_new = 1'b1;
			tbl_valid[e] = 1'b1;
			tbl_addr[e] = a;
			tbl_id[e] = id_next;
			id_next = id_next + 32'd1;
			if (id_next == 0) id_next = 32'd1;
			tbl_nsamp[e] = 0;
			tbl_filt[e] = 0;
			tbl_count[e] = '0;
			tbl_seq[e] = '0;
			tbl_ap[e] = 1'b0;
		end
		n = tbl_nsamp[e];
		if (n < WINDOW) begin
			tbl_samp[e][n] = r;
			n++;
		end else begin
			for (int i = 1; i < WINDOW; i++) tbl_samp[e][i-1] = tbl_samp[e][i];
			tbl_samp[e][WINDOW-1] = r;
		end
		tbl_nsamp[e] = n;
		for (int i = 0; i < n; i++) begin
			v = tbl_samp[e][i];
			j = i;
			while (j > 0 && srt[j-1] > v) begin
				srt[j] = srt[j-1];
				j--;
			end
			srt[j] = v;
		end
		med = srt[n/2];
		if (tbl_count[e] == 0) f = med * 256;
		else f = tbl_filt[e] + (med * 256 - tbl_filt[e]) / 4;
		tbl_filt[e] = f;
		if (ap) tbl_ap[e] = 1'b1;
		if (tbl_count[e] != 16'hFFFF) tbl_count[e]++;
		tbl_seq[e]++;
		if (tbl_seq[e] == 0) tbl_seq[e] = 16'd1;
		tbl_last[e] = t;
		res.accepted = 1'b1;
		res.slot = e[4:0];
		res.target_id = tbl_id[e];
		res.median_rssi = med[7:0];
		res.smooth_rssi = 8'(f / 256);
		res.sighting_count = tbl_count[e];
		res.sequence_res = tbl_seq[e];
		res.entry_is_ap = tbl_ap[e];
		return res;
	endfunction

	task automatic report(string field, logic [63:0] got, logic [63:0] exp);
		$display("mismatch %s: got %0h expected %0h at %0t", field, got, exp, $realtime);
		errors++;
	endtask

	// one input transaction; valid stays high across back-to-back items
	task automatic send_sighting(logic [47:0] a, logic ap, logic signed [7:0] r,
			logic [3:0] ch, logic [31:0] t);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, STALL_MAX);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		address <= a;
		is_ap <= ap;
		rssi <= r;
		channel <= ch;
		now_ms <= t;
		do @(posedge clk); while (in_stall);
		pending_results.push_back(track_sighting(a, ap, r, t));
	endtask

	task automatic sight(logic [47:0] a, logic signed [7:0] r);
		clock_ms = clock_ms + $urandom_range(0, 2000);
		send_sighting(a, $urandom_range(0, 3) == 0, r, 4'($urandom_range(0, 15)), clock_ms);
	endtask

	// output side: compare each result transaction and draw the next stall
	int stall_left = 0;
	always @(posedge clk) begin
		sighting_res_t exp;
		if (out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				$display("unexpected result transaction at %0t", $realtime);
				errors++;
			end else begin
				exp = pending_results.pop_front();
				if (accepted !== exp.accepted) report("accepted", accepted, exp.accepted);
				if (slot !== exp.slot) report("slot", slot, exp.slot);
				if (target_id !== exp.target_id) report("target_id", target_id, exp.target_id);
				if (is_new !== exp.is_new) report("is_new", is_new, exp.is_new);
				if (evicted !== exp.evicted) report("evicted", evicted, exp.evicted);
				if (median_rssi !== exp.median_rssi)
					report("median_rssi", median_rssi, exp.median_rssi);
				if (smooth_rssi !== exp.smooth_rssi)
					report("smooth_rssi", smooth_rssi, exp.smooth_rssi);
				if (sighting_count !== exp.sighting_count)
					report("sighting_count", sighting_count, exp.sighting_count);
				if (sequence_res !== exp.sequence_res)
					report("sequence_res", sequence_res, exp.sequence_res);
				if (entry_is_ap !== exp.entry_is_ap)
					report("entry_is_ap", entry_is_ap, exp.entry_is_ap);
			end
			stall_left = quiet ? 0 : $urandom_range(0, STALL_MAX);
		end else if (stall_left > 0) begin
			stall_left--;
		end
		out_stall <= (stall_left != 0);
	end

	// watchdog on cycles without any transaction
	int idle_cycles = 0;
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
		else idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// broadcast and all-zero addresses, plus neighbors that are valid
	task automatic test_rejected();
		send_sighting('0, 1'b1, 8'sd127, 4'd15, 32'hFFFF_FFFF);
		send_sighting(BCAST, 1'b0, -8'sd128, 4'd0, 32'd0);
		send_sighting(48'h1, 1'b0, -8'sd128, 4'd0, 32'd1);
		send_sighting(48'hFFFF_FFFF_FFFE, 1'b1, 8'sd127, 4'd15, 32'd2);
	endtask

	// window fill, shift-out, filter convergence and sticky ap flag
	task automatic test_window_filter();
		logic [47:0] a;
		a = 48'hA5A5_5A5A_0F0F;
		send_sighting(a, 1'b1, -8'sd128, 4'd3, 32'd10);
		send_sighting(a, 1'b0, 8'sd127, 4'd4, 32'd20);
		send_sighting(a, 1'b0, 8'sd127, 4'd5, 32'd30);
		send_sighting(a, 1'b0, -8'sd1, 4'd6, 32'd40);
		send_sighting(a, 1'b0, 8'sd0, 4'd7, 32'd50);
		send_sighting(a, 1'b0, 8'sd1, 4'd8, 32'd60);
		send_sighting(a, 1'b0, -8'sd127, 4'd9, 32'd70);
		send_sighting(a, 1'b0, -8'sd128, 4'd10, 32'd80);
		send_sighting(a, 1'b0, -8'sd128, 4'd11, 32'd90);
		send_sighting(a, 1'b0, -8'sd128, 4'd12, 32'd100);
		send_sighting(48'h5A5A_A5A5_F0F0, 1'b0, 8'sd127, 4'd1, 32'h8000_0000);
		send_sighting(48'h5A5A_A5A5_F0F0, 1'b0, -8'sd128, 4'd2, 32'hFFFF_FFF0);
	endtask

	// fill the table, then force evictions with ties and wrapped times
	task automatic test_eviction();
		logic [47:0] a;
		for (int k = 0; k < ENTRIES + 8; k++) begin
			a = {$urandom, 16'($urandom)} | 48'h1;
			if (k % 7 == 3) send_sighting(a, 1'b0, 8'($urandom), 4'($urandom), clock_ms);
			else sight(a, 8'($urandom));
			addr_pool.push_back(a);
		end
		clock_ms = 32'hFFFF_FF00;
		for (int k = 0; k < 12; k++) sight({$urandom, 16'($urandom)} | 48'h2, 8'($urandom));
	endtask

	// random bursts over address pools of varying size
	task automatic test_random(int items);
		int sent;
		int burst;
		int pool_sz;
		int pick;
		logic [47:0] a;
		sent = 0;
		while (sent < items) begin
			quiet = ($urandom_range(0, 5) == 0);
			pool_sz = ($urandom_range(0, 2) == 0) ? 48 : $urandom_range(1, 10);
			addr_pool.delete();
			for (int k = 0; k < pool_sz; k++)
				addr_pool.push_back({$urandom, 16'($urandom)});
			if ($urandom_range(0, 3) == 0) clock_ms = $urandom;
			burst = $urandom_range(20, 80);
			for (int k = 0; k < burst; k++) begin
				pick = $urandom_range(0, 19);
				if (pick == 0) a = '0;
				else if (pick == 1) a = BCAST;
				else a = addr_pool[$urandom_range(0, pool_sz - 1)];
				sight(a, 8'($urandom));
			end
			sent += burst;
		end
		quiet = 1'b0;
	endtask

	initial begin
		for (int i = 0; i < ENTRIES; i++) tbl_valid[i] = 1'b0;
		id_next = 32'd1;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_rejected();
		test_window_filter();
		test_eviction();
		test_random(1000);
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (errors == 0 && pending_results.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
